[rtl/rpe_pkg.sv]
package rpe_pkg;

	localparam int TRIG_WIDTH = 16;
	localparam int FRAC_SHIFT = 14;
	localparam int DIM_WIDTH  = 7;
	localparam int HALF_WIDTH = 7;

	localparam logic [HALF_WIDTH-1:0] HALF_RESET = 7'd64;

	typedef struct packed {
		logic [DIM_WIDTH-1:0] lo_dim;
		logic [DIM_WIDTH-1:0] hi_dim;
		logic                 last;
	} rpe_tag_t;

endpackage

[rtl/rpe_rotate.sv]
module rpe_rotate #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic signed [SAMPLE_WIDTH-1:0]       x_cur,
	input  logic signed [rpe_pkg::TRIG_WIDTH-1:0] cos_cur,
	input  logic signed [rpe_pkg::TRIG_WIDTH-1:0] sin_cur,
	input  logic signed [SAMPLE_WIDTH-1:0]       x_buf,
	input  logic signed [rpe_pkg::TRIG_WIDTH-1:0] cos_buf,
	input  logic signed [rpe_pkg::TRIG_WIDTH-1:0] sin_buf,
	input  rpe_pkg::rpe_tag_t                    tag_in,
	output rpe_pkg::rpe_tag_t                    tag_out,
	output logic [SAMPLE_WIDTH-1:0]              lo_result,
	output logic [SAMPLE_WIDTH-1:0]              hi_result
);

	localparam int PW = SAMPLE_WIDTH + rpe_pkg::TRIG_WIDTH;
	localparam int AW = PW + 1;
	localparam int RW = AW - rpe_pkg::FRAC_SHIFT;
	localparam logic [AW-1:0] RND = AW'(1) << (rpe_pkg::FRAC_SHIFT - 1);

	logic signed [PW-1:0] xb_cb_s2;
	logic signed [PW-1:0] xc_sb_s2;
	logic signed [PW-1:0] xc_cc_s2;
	logic signed [PW-1:0] xb_sc_s2;
	rpe_pkg::rpe_tag_t    tag_s2;

	logic [AW-1:0] lo_acc;
	logic [AW-1:0] hi_acc;

	function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic [AW-1:0] acc);
		logic [AW-1:0] biased;
		logic [RW-1:0] r;
		logic [RW-SAMPLE_WIDTH:0] top;
		biased = acc + RND;
		r = biased[AW-1:rpe_pkg::FRAC_SHIFT];
		top = r[RW-1:SAMPLE_WIDTH-1];
		if (top == '0 || top == '1) begin
			return r[SAMPLE_WIDTH-1:0];
		end else if (r[RW-1]) begin
			return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	endfunction

	always_ff @(posedge clk) begin
		if (load) begin
			xb_cb_s2 <= x_buf * cos_buf;
			xc_sb_s2 <= x_cur * sin_buf;
			xc_cc_s2 <= x_cur * cos_cur;
			xb_sc_s2 <= x_buf * sin_cur;
			tag_s2   <= tag_in;
		end
	end

	assign lo_acc = {xb_cb_s2[PW-1], xb_cb_s2} - {xc_sb_s2[PW-1], xc_sb_s2};
	assign hi_acc = {xc_cc_s2[PW-1], xc_cc_s2} + {xb_sc_s2[PW-1], xb_sc_s2};

	assign lo_result = round_sat(lo_acc);
	assign hi_result = round_sat(hi_acc);
	assign tag_out   = tag_s2;

endmodule

[rtl/rotary_position_embedding_top.sv]
// Rotary position embedding, rotate-half form, streamed one element per item.
// Input channel (in_valid/in_ready): sample, cos_value, sin_value of the next
// element of a head vector of 2*half_dim elements; the dimension comes from an
// internal position counter. First-half items are stored in an on-chip buffer
// and give no result. Each second-half item d+h gives two result items on the
// output channel (out_valid/out_ready): dimension d first, then d+h, with last
// set on the second result of the final element.
// Pipeline: the input/buffer read register loads on acceptance, then the
// product register, then the result register, which drives out_valid.
// First-half items are taken one per cycle while in_ready is high; second-half
// items are limited by the single result port that shows two results each.
// cfg_wr_en writes half_dim (0 acts as 1, values above MAX_HALF_DIM are
// clamped) and restarts the position at 0; write only while idle.
// Reset clears the position, the pipeline valids and sets half_dim to 64; the
// buffer is not cleared. When out_ready is low the result is held and the
// pipeline fills; in_ready drops once every stage holds an item.
module rotary_position_embedding_top #(
	parameter int MAX_HALF_DIM = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [rpe_pkg::HALF_WIDTH-1:0]        cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample,
	input  logic signed [rpe_pkg::TRIG_WIDTH-1:0] cos_value,
	input  logic signed [rpe_pkg::TRIG_WIDTH-1:0] sin_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]        rotated,
	output logic [rpe_pkg::DIM_WIDTH-1:0]         dim_index,
	output logic                                  last
);

	localparam int AW = (MAX_HALF_DIM > 1) ? $clog2(MAX_HALF_DIM) : 1;
	localparam int EW = $clog2(2 * MAX_HALF_DIM + 1);
	localparam int TW = (EW > 8) ? EW : 8;
	localparam int TRW = rpe_pkg::TRIG_WIDTH;
	localparam int MW = SAMPLE_WIDTH + 2 * TRW;

	logic [rpe_pkg::HALF_WIDTH-1:0] half_dim_q;
	logic [TW-1:0]                  pos_q;

	logic [TW-1:0] h_eff;
	logic [TW-1:0] pos_cur;
	logic [TW-1:0] d_cur;
	logic          first_half;
	logic          vec_end;
	logic [AW-1:0] buf_addr;
	logic          in_fire;

	logic [MW-1:0] buf_mem [MAX_HALF_DIM];
	logic [MW-1:0] rd_s1;

	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic signed [TRW-1:0]          c_s1;
	logic signed [TRW-1:0]          s_s1;
	rpe_pkg::rpe_tag_t              tag_s1;
	rpe_pkg::rpe_tag_t              tag_in_cur;
	logic                           v_s1;
	logic                           v_s2;

	rpe_pkg::rpe_tag_t              tag_s2;
	logic [SAMPLE_WIDTH-1:0]        lo_res;
	logic [SAMPLE_WIDTH-1:0]        hi_res;

	logic [SAMPLE_WIDTH-1:0]        lo_q;
	logic [SAMPLE_WIDTH-1:0]        hi_q;
	rpe_pkg::rpe_tag_t              tag_q;
	logic                           out_v_q;
	logic                           phase_q;

	logic out_load;
	logic s2_go;
	logic s1_go;

	always_comb begin
		if (half_dim_q == '0) begin
			h_eff = TW'(1);
		end else if (TW'(half_dim_q) > TW'(MAX_HALF_DIM)) begin
			h_eff = TW'(MAX_HALF_DIM);
		end else begin
			h_eff = TW'(half_dim_q);
		end
		pos_cur    = (pos_q >= (h_eff << 1)) ? '0 : pos_q;
		first_half = pos_cur < h_eff;
		d_cur      = pos_cur - h_eff;
		vec_end    = pos_cur == ((h_eff << 1) - TW'(1));
		buf_addr   = first_half ? pos_cur[AW-1:0] : d_cur[AW-1:0];
		tag_in_cur.lo_dim = d_cur[rpe_pkg::DIM_WIDTH-1:0];
		tag_in_cur.hi_dim = pos_cur[rpe_pkg::DIM_WIDTH-1:0];
		tag_in_cur.last   = vec_end;
	end

	assign out_load = !out_v_q || (out_ready && phase_q);
	assign s2_go    = !v_s2 || out_load;
	assign s1_go    = !v_s1 || s2_go;
	assign in_ready = s1_go;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_dim_q <= rpe_pkg::HALF_RESET;
			pos_q      <= '0;
		end else if (cfg_wr_en) begin
			half_dim_q <= cfg_wr_data;
			pos_q      <= '0;
		end else if (in_fire) begin
			pos_q <= (!first_half && vec_end) ? '0 : pos_cur + TW'(1);
		end
	end

	// buffer: write first-half items, read the partner for second-half items
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (first_half) begin
				buf_mem[buf_addr] <= {sample, cos_value, sin_value};
			end else begin
				rd_s1 <= buf_mem[buf_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !first_half) begin
			x_s1   <= sample;
			c_s1   <= cos_value;
			s_s1   <= sin_value;
			tag_s1 <= tag_in_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_go) begin
				v_s1 <= in_fire && !first_half;
			end
			if (s2_go) begin
				v_s2 <= v_s1;
			end
		end
	end

	rpe_rotate #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_rotate (
		.clk       (clk),
		.load      (s2_go),
		.x_cur     (x_s1),
		.cos_cur   (c_s1),
		.sin_cur   (s_s1),
		.x_buf     (rd_s1[MW-1:2*TRW]),
		.cos_buf   (rd_s1[2*TRW-1:TRW]),
		.sin_buf   (rd_s1[TRW-1:0]),
		.tag_in    (tag_s1),
		.tag_out   (tag_s2),
		.lo_result (lo_res),
		.hi_result (hi_res)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			lo_q  <= lo_res;
			hi_q  <= hi_res;
			tag_q <= tag_s2;
		end
	end

	// show the low result first, then advance to the high result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= v_s2;
			phase_q <= 1'b0;
		end else if (out_ready) begin
			phase_q <= 1'b1;
		end
	end

	assign out_valid = out_v_q;
	assign rotated   = phase_q ? hi_q : lo_q;
	assign dim_index = phase_q ? tag_q.hi_dim : tag_q.lo_dim;
	assign last      = phase_q && tag_q.last;

endmodule
